/* src/ppk_pkg.sv */
`timescale 1ns / 1ps

package ppk_pkg;

    localparam int KEY_W        = 64;
    localparam int PAGE_W       = 16;
    localparam int HDR_W        = 6;
    localparam int QUO_W        = 16;
    localparam int DIV_CNT_W    = 4;
    localparam int CNT_OUT_W    = 48;
    localparam int PREFIX_OUT_W = 5;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int BYTE_COUNT_W = 4;

    localparam logic [PAGE_W-1:0]    PAGE_BYTES_RST = 16'd4096;
    localparam logic [HDR_W-1:0]     HDR_BYTES_RST  = 6'd9;
    localparam logic [QUO_W-1:0]     CAP_MAX        = 16'hFFFF;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST       = 4'd15;
    localparam logic [BYTE_COUNT_W-1:0] WORD_BYTES  = 4'd8;

    // Register index, taken from paddr[2].
    localparam logic REG_PAGE_BYTES = 1'b0;
    localparam logic REG_HDR_BYTES  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_DIV,
        ST_COMMIT
    } ppk_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic div_init;
        logic div_step;
        logic commit;
    } ppk_cmd_t;

    typedef struct packed {
        logic started;
        logic same;
        logic scan_last;
        logic out_free;
    } ppk_status_t;

    // Leading equal bytes of two words, most significant byte first.
    function automatic logic [BYTE_COUNT_W-1:0] lead_eq_bytes(
        input logic [KEY_W-1:0] a,
        input logic [KEY_W-1:0] b
    );
        logic [BYTE_COUNT_W-1:0] n;
        logic                    diff;
        n    = '0;
        diff = 1'b0;
        for (int s = 7; s >= 0; s--)
        begin
            if (a[s*8 +: 8] != b[s*8 +: 8])
            begin
                diff = 1'b1;
            end
            if (!diff)
            begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

endpackage

/* src/prefix_compressed_page_packer_top.sv */
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// input     in_valid/in_stall   key_word0, key_word1, key_word2
// output    out_valid/out_stall is_repeat, opened_page, prefix_len, page_total,
//                               page_fill, repeat_total, key_total
// config    APB write/read      page_bytes at 0x0, header_bytes at 0x4
//
// One request at a time. A new key runs the one-word-a-cycle prefix scan and then
// the sixteen-step radix-2 divider that works out the page capacity; the first
// key and a repeat skip the divider.
// Reset is asynchronous and active low. The result sits in an output register;
// while it stalls, a finished request waits before its commit.

module prefix_compressed_page_packer_top
    import ppk_pkg::*;
#(
    parameter int KEY_WORDS  = 3,
    parameter int COUNT_BITS = 48
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [KEY_W-1:0]        key_word0,
    input  logic [KEY_W-1:0]        key_word1,
    input  logic [KEY_W-1:0]        key_word2,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    is_repeat,
    output logic                    opened_page,
    output logic [PREFIX_OUT_W-1:0] prefix_len,
    output logic [CNT_OUT_W-1:0]    page_total,
    output logic [PAGE_W-1:0]       page_fill,
    output logic [CNT_OUT_W-1:0]    repeat_total,
    output logic [CNT_OUT_W-1:0]    key_total
);

    logic [PAGE_W-1:0] page_bytes_reg;
    logic [HDR_W-1:0]  header_bytes_reg;
    logic              wr_en;
    ppk_cmd_t          cmd;
    ppk_status_t       status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_bytes_reg   <= PAGE_BYTES_RST;
            header_bytes_reg <= HDR_BYTES_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_PAGE_BYTES: page_bytes_reg   <= pwdata[PAGE_W-1:0];
                REG_HDR_BYTES:  header_bytes_reg <= pwdata[HDR_W-1:0];
                default:        page_bytes_reg   <= page_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PAGE_BYTES: prdata = APB_DATA_W'(page_bytes_reg);
            REG_HDR_BYTES:  prdata = APB_DATA_W'(header_bytes_reg);
            default:        prdata = '0;
        endcase
    end

    ppk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ppk_datapath #(
        .KEY_WORDS  (KEY_WORDS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .key_word0    (key_word0),
        .key_word1    (key_word1),
        .key_word2    (key_word2),
        .page_bytes   (page_bytes_reg),
        .header_bytes (header_bytes_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_repeat    (is_repeat),
        .opened_page  (opened_page),
        .prefix_len   (prefix_len),
        .page_total   (page_total),
        .page_fill    (page_fill),
        .repeat_total (repeat_total),
        .key_total    (key_total)
    );

endmodule

/* src/ppk_ctrl.sv */
`timescale 1ns / 1ps

module ppk_ctrl
    import ppk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ppk_status_t status,
    output ppk_cmd_t    cmd
);

    ppk_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // The first key and a repeat need no capacity.
                if (!status.started || status.same)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/ppk_datapath.sv */
`timescale 1ns / 1ps

module ppk_datapath
    import ppk_pkg::*;
#(
    parameter int KEY_WORDS  = 3,
    parameter int COUNT_BITS = 48
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ppk_cmd_t                cmd,
    output ppk_status_t             status,
    input  logic [KEY_W-1:0]        key_word0,
    input  logic [KEY_W-1:0]        key_word1,
    input  logic [KEY_W-1:0]        key_word2,
    input  logic [PAGE_W-1:0]       page_bytes,
    input  logic [HDR_W-1:0]        header_bytes,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    is_repeat,
    output logic                    opened_page,
    output logic [PREFIX_OUT_W-1:0] prefix_len,
    output logic [CNT_OUT_W-1:0]    page_total,
    output logic [PAGE_W-1:0]       page_fill,
    output logic [CNT_OUT_W-1:0]    repeat_total,
    output logic [CNT_OUT_W-1:0]    key_total
);

    localparam int KEY_BYTES = 8 * KEY_WORDS;
    localparam int PFX_W     = $clog2(KEY_BYTES + 1);
    localparam int WIDX_W    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int USED_W    = ((PFX_W > HDR_W) ? PFX_W : HDR_W) + 1;
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(KEY_WORDS - 1);
    localparam logic [PFX_W-1:0]  KEY_BYTES_V = PFX_W'(KEY_BYTES);

    logic [KEY_W-1:0] key_reg   [KEY_WORDS];
    logic [KEY_W-1:0] first_reg [KEY_WORDS];
    logic [KEY_W-1:0] prev_reg  [KEY_WORDS];

    logic [WIDX_W-1:0]     ptr_reg;
    logic [PFX_W-1:0]      pfx_reg;
    logic                  mism_reg;
    logic                  same_reg;
    logic [PFX_W-1:0]      rem_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [PFX_W-1:0]      den_reg;
    logic                  started_reg;
    logic [COUNT_BITS-1:0] pages_reg, pages_next;
    logic [PAGE_W-1:0]     kip_reg, kip_next;
    logic [COUNT_BITS-1:0] reps_reg, reps_next;
    logic [COUNT_BITS-1:0] keys_reg, keys_next;
    logic                  out_valid_reg;
    logic                  opened_next;
    logic                  rep_next;
    logic                  take_key;

    logic [BYTE_COUNT_W-1:0] word_eq;
    logic [USED_W-1:0]       used;
    logic [PFX_W:0]          rem_sh;
    logic [QUO_W-1:0]        cap;
    logic                    fits;

    assign status.started   = started_reg;
    assign status.same      = same_reg;
    assign status.scan_last = (ptr_reg == LAST_WORD);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign word_eq = lead_eq_bytes(key_reg[ptr_reg], first_reg[ptr_reg]);
    assign used    = USED_W'(header_bytes) + USED_W'(pfx_reg);
    assign rem_sh  = {rem_reg, quo_reg[QUO_W-1]};
    assign cap     = (den_reg == '0) ? CAP_MAX : quo_reg;
    assign fits    = ({1'b0, kip_reg} + 1'b1) <= {1'b0, cap};

    // Effect of the request on the running totals, applied at commit.
    always_comb
    begin
        pages_next  = pages_reg;
        kip_next    = kip_reg;
        reps_next   = reps_reg;
        keys_next   = (&keys_reg) ? keys_reg : keys_reg + 1'b1;
        opened_next = 1'b0;
        rep_next    = 1'b0;
        take_key    = 1'b0;
        if (!started_reg)
        begin
            pages_next  = COUNT_BITS'(1);
            kip_next    = PAGE_W'(1);
            keys_next   = COUNT_BITS'(1);
            opened_next = 1'b1;
            take_key    = 1'b1;
        end
        else if (same_reg)
        begin
            rep_next  = 1'b1;
            reps_next = (&reps_reg) ? reps_reg : reps_reg + 1'b1;
        end
        else if (fits)
        begin
            kip_next = kip_reg + 1'b1;
        end
        else
        begin
            pages_next  = (&pages_reg) ? pages_reg : pages_reg + 1'b1;
            kip_next    = PAGE_W'(1);
            opened_next = 1'b1;
            take_key    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int w = 0; w < KEY_WORDS; w++)
            begin
                case (w)
                    0:       key_reg[w] <= key_word0;
                    1:       key_reg[w] <= key_word1;
                    2:       key_reg[w] <= key_word2;
                    default: key_reg[w] <= '0;
                endcase
            end
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            den_reg <= KEY_BYTES_V - pfx_reg;
            quo_reg <= (page_bytes > PAGE_W'(used)) ? page_bytes - PAGE_W'(used) : '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= PFX_W'(rem_sh - {1'b0, den_reg});
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[PFX_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.commit)
        begin
            if (!started_reg || !same_reg)
            begin
                for (int w = 0; w < KEY_WORDS; w++)
                begin
                    prev_reg[w] <= key_reg[w];
                end
            end
            if (take_key)
            begin
                for (int w = 0; w < KEY_WORDS; w++)
                begin
                    first_reg[w] <= key_reg[w];
                end
            end
            is_repeat    <= rep_next;
            opened_page  <= opened_next;
            prefix_len   <= started_reg ? PREFIX_OUT_W'(pfx_reg) : '0;
            page_total   <= CNT_OUT_W'(pages_next);
            page_fill    <= kip_next;
            repeat_total <= CNT_OUT_W'(reps_next);
            key_total    <= CNT_OUT_W'(keys_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            pfx_reg       <= '0;
            mism_reg      <= 1'b0;
            same_reg      <= 1'b0;
            started_reg   <= 1'b0;
            pages_reg     <= '0;
            kip_reg       <= '0;
            reps_reg      <= '0;
            keys_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ptr_reg  <= '0;
                pfx_reg  <= '0;
                mism_reg <= 1'b0;
                same_reg <= 1'b1;
            end
            else if (cmd.scan)
            begin
                // One word a cycle; the count stops at the first differing byte.
                if (!mism_reg)
                begin
                    pfx_reg <= pfx_reg + PFX_W'(word_eq);
                    if (word_eq != WORD_BYTES)
                    begin
                        mism_reg <= 1'b1;
                    end
                end
                if (key_reg[ptr_reg] != prev_reg[ptr_reg])
                begin
                    same_reg <= 1'b0;
                end
                if (ptr_reg != LAST_WORD)
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                started_reg   <= 1'b1;
                pages_reg     <= pages_next;
                kip_reg       <= kip_next;
                reps_reg      <= reps_next;
                keys_reg      <= keys_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* tb/sv/page_packer_checker.sv */
`timescale 1ns / 1ps

module page_packer_checker
    import ppk_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic                    pready,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [KEY_W-1:0]        key_word0,
    input  logic [KEY_W-1:0]        key_word1,
    input  logic [KEY_W-1:0]        key_word2,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic                    is_repeat,
    input  logic                    opened_page,
    input  logic [PREFIX_OUT_W-1:0] prefix_len,
    input  logic [CNT_OUT_W-1:0]    page_total,
    input  logic [PAGE_W-1:0]       page_fill,
    input  logic [CNT_OUT_W-1:0]    repeat_total,
    input  logic [CNT_OUT_W-1:0]    key_total,
    output int                      errors,
    output int                      pending
);

    localparam int KEY_BITS  = 3 * KEY_W;
    localparam int KEY_BYTES = KEY_BITS / 8;
    localparam logic [CNT_OUT_W-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic                    is_repeat;
        logic                    opened_page;
        logic [PREFIX_OUT_W-1:0] prefix_len;
        logic [CNT_OUT_W-1:0]    page_total;
        logic [PAGE_W-1:0]       page_fill;
        logic [CNT_OUT_W-1:0]    repeat_total;
        logic [CNT_OUT_W-1:0]    key_total;
    } packing_t;

    logic [PAGE_W-1:0]    page_bytes_cfg;
    logic [HDR_W-1:0]     header_bytes_cfg;
    logic                 begun;
    logic [KEY_BITS-1:0]  page_head;
    logic [KEY_BITS-1:0]  prior_key;
    logic [CNT_OUT_W-1:0] pages;
    logic [CNT_OUT_W-1:0] repeats;
    logic [CNT_OUT_W-1:0] keys;
    logic [PAGE_W-1:0]    fill;
    packing_t             due_packings[$];
    packing_t             got;
    packing_t             want;
    int                   results_seen;

    function automatic logic [CNT_OUT_W-1:0] bump(input logic [CNT_OUT_W-1:0] v);
        return (v == COUNT_TOP) ? v : v + 1'b1;
    endfunction

    // Equal leading bytes, most significant byte of word 0 first.
    function automatic int shared_prefix(input logic [KEY_BITS-1:0] a,
                                         input logic [KEY_BITS-1:0] b);
        int   n;
        logic differs;
        n       = 0;
        differs = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (a[KEY_BITS-1-8*i -: 8] != b[KEY_BITS-1-8*i -: 8])
            begin
                differs = 1'b1;
            end
            if (!differs)
            begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic packing_t pack_key(input logic [KEY_BITS-1:0] key);
        packing_t r;
        int       prefix;
        int       used;
        int       num;
        int       den;
        int       cap;
        r      = '0;
        prefix = 0;
        if (!begun)
        begin
            begun         = 1'b1;
            page_head     = key;
            prior_key     = key;
            pages         = CNT_OUT_W'(1);
            fill          = PAGE_W'(1);
            keys          = CNT_OUT_W'(1);
            r.opened_page = 1'b1;
        end
        else
        begin
            keys   = bump(keys);
            prefix = shared_prefix(key, page_head);
            if (key == prior_key)
            begin
                r.is_repeat = 1'b1;
                repeats     = bump(repeats);
            end
            else
            begin
                used = int'(header_bytes_cfg) + prefix;
                num  = (int'(page_bytes_cfg) > used) ? int'(page_bytes_cfg) - used : 0;
                den  = KEY_BYTES - prefix;
                // A key equal to the page's first key leaves nothing to divide by.
                cap  = (den == 0) ? 65535 : num / den;
                if (cap > 65535)
                begin
                    cap = 65535;
                end
                prior_key = key;
                if (int'(fill) + 1 <= cap)
                begin
                    fill = fill + 1'b1;
                end
                else
                begin
                    pages         = bump(pages);
                    fill          = PAGE_W'(1);
                    page_head     = key;
                    r.opened_page = 1'b1;
                end
            end
        end
        r.prefix_len   = PREFIX_OUT_W'(prefix);
        r.page_total   = pages;
        r.page_fill    = fill;
        r.repeat_total = repeats;
        r.key_total    = keys;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        errors++;
        $display("result %0d: %s is %0h, expected %0h", results_seen, field, got_v, want_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_bytes_cfg   <= PAGE_BYTES_RST;
            header_bytes_cfg <= HDR_BYTES_RST;
            begun            = 1'b0;
            page_head        = '0;
            prior_key        = '0;
            pages            = '0;
            repeats          = '0;
            keys             = '0;
            fill             = '0;
            results_seen     = 0;
            due_packings.delete();
            pending          = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_PAGE_BYTES: page_bytes_cfg   <= pwdata[PAGE_W-1:0];
                    REG_HDR_BYTES:  header_bytes_cfg <= pwdata[HDR_W-1:0];
                    default:        page_bytes_cfg   <= page_bytes_cfg;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got = {is_repeat, opened_page, prefix_len, page_total, page_fill,
                       repeat_total, key_total};
                if (due_packings.size() == 0)
                begin
                    report_mismatch("result without a request", 1, 0);
                end
                else
                begin
                    want = due_packings.pop_front();
                    if (got.is_repeat != want.is_repeat)
                        report_mismatch("is_repeat", got.is_repeat, want.is_repeat);
                    if (got.opened_page != want.opened_page)
                        report_mismatch("opened_page", got.opened_page, want.opened_page);
                    if (got.prefix_len != want.prefix_len)
                        report_mismatch("prefix_len", got.prefix_len, want.prefix_len);
                    if (got.page_total != want.page_total)
                        report_mismatch("page_total", got.page_total, want.page_total);
                    if (got.page_fill != want.page_fill)
                        report_mismatch("page_fill", got.page_fill, want.page_fill);
                    if (got.repeat_total != want.repeat_total)
                        report_mismatch("repeat_total", got.repeat_total, want.repeat_total);
                    if (got.key_total != want.key_total)
                        report_mismatch("key_total", got.key_total, want.key_total);
                end
            end
            if (in_valid && !in_stall)
            begin
                due_packings.push_back(pack_key({key_word0, key_word1, key_word2}));
            end
            pending = due_packings.size();
        end
    end

endmodule

/* tb/sv/prefix_compressed_page_packer_top_test.sv */
`timescale 1ns / 1ps

module prefix_compressed_page_packer_top_test;

    import ppk_pkg::*;

    localparam int KEY_BITS  = 3 * KEY_W;
    localparam int LIMIT     = 300000;
    localparam int SETTLE    = 30;
    localparam int HOLD_OFF  = 700;
    localparam int PHASES    = 7;
    localparam int PER_PHASE = 92;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    psel      = 1'b0;
    logic                    penable   = 1'b0;
    logic                    pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr     = '0;
    logic [APB_DATA_W-1:0]   pwdata    = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic [KEY_W-1:0]        key_word0 = '0;
    logic [KEY_W-1:0]        key_word1 = '0;
    logic [KEY_W-1:0]        key_word2 = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    is_repeat;
    logic                    opened_page;
    logic [PREFIX_OUT_W-1:0] prefix_len;
    logic [CNT_OUT_W-1:0]    page_total;
    logic [PAGE_W-1:0]       page_fill;
    logic [CNT_OUT_W-1:0]    repeat_total;
    logic [CNT_OUT_W-1:0]    key_total;

    int          errors;
    int          pending;
    int unsigned cycles    = 0;
    int          src_max   = 12;
    int          sink_max  = 12;
    int          sink_gap  = 0;
    logic        press_arm = 1'b0;
    logic        hold_on   = 1'b0;

    prefix_compressed_page_packer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_word0    (key_word0),
        .key_word1    (key_word1),
        .key_word2    (key_word2),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_repeat    (is_repeat),
        .opened_page  (opened_page),
        .prefix_len   (prefix_len),
        .page_total   (page_total),
        .page_fill    (page_fill),
        .repeat_total (repeat_total),
        .key_total    (key_total)
    );

    page_packer_checker packing_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_word0    (key_word0),
        .key_word1    (key_word1),
        .key_word2    (key_word2),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_repeat    (is_repeat),
        .opened_page  (opened_page),
        .prefix_len   (prefix_len),
        .page_total   (page_total),
        .page_fill    (page_fill),
        .repeat_total (repeat_total),
        .key_total    (key_total),
        .errors       (errors),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // After each result it takes, the receiver draws a random stall that counts down only while a result is offered.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_gap = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                sink_gap = $urandom_range(0, sink_max);
            end
            else if (out_valid && sink_gap > 0)
            begin
                sink_gap = sink_gap - 1;
            end
            out_stall <= (sink_gap > 0) || hold_on;
        end
    end

    // One long hold-off on the result side, so that requests back up.
    initial
    begin
        wait (press_arm);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_on = 1'b0;
    end

    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic offer_key(input logic [KEY_BITS-1:0] key);
        int gap;
        gap = $urandom_range(0, src_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_word0 <= key[KEY_BITS-1 -: KEY_W];
        key_word1 <= key[2*KEY_W-1 -: KEY_W];
        key_word2 <= key[KEY_W-1:0];
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Registers only change once every request has come back out.
    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mostly an ascending walk that bumps one byte and sometimes scrambles the
    // bytes below it; the rest are repeats, random keys and returns to an older key.
    function automatic logic [KEY_BITS-1:0] pick_key(input logic [KEY_BITS-1:0] cur,
                                                     input logic [KEY_BITS-1:0] anchor);
        logic [KEY_BITS-1:0] k;
        logic [KEY_BITS-1:0] noise;
        logic [KEY_BITS-1:0] low_mask;
        int                  roll;
        int                  pos;
        roll  = $urandom_range(0, 99);
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (roll < 12)
        begin
            k = cur;
        end
        else if (roll < 20)
        begin
            k = noise;
        end
        else if (roll < 25)
        begin
            k = anchor;
        end
        else
        begin
            pos      = (roll < 60) ? $urandom_range(16, 23) : $urandom_range(0, 23);
            low_mask = (KEY_BITS'(1) << (8 * (23 - pos))) - KEY_BITS'(1);
            k        = cur + (KEY_BITS'(1) << (8 * (23 - pos)));
            if ($urandom_range(0, 1) == 1)
            begin
                k = (k & ~low_mask) | (noise & low_mask);
            end
        end
        return k;
    endfunction

    initial
    begin
        logic [KEY_BITS-1:0] cursor;
        logic [KEY_BITS-1:0] anchor;
        logic [KEY_BITS-1:0] k;
        int                  pg;
        int                  hd;

        cursor = '0;
        anchor = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: first key, repeats, deep and shallow prefixes,
        // all-ones words and a return to the page's first key.
        offer_key({64'h0, 64'h0, 64'h0});
        offer_key({64'h0, 64'h0, 64'h0});
        offer_key({64'h0, 64'h0, 64'h1});
        offer_key({64'h0, 64'h0, 64'h1});
        offer_key({64'h0, 64'h1, 64'h0});
        offer_key({64'h0100_0000_0000_0000, 64'h0, 64'h0});
        offer_key({64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000});
        offer_key({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        offer_key({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        offer_key({64'h0, 64'h0, 64'h0});
        offer_key({64'h0, 64'h0, 64'h0});

        // A 64-byte page with a 40-byte header: one key per page.
        settle();
        write_reg(REG_PAGE_BYTES, 32'd64);
        write_reg(REG_HDR_BYTES, 32'd40);
        offer_key({64'h0200_0000_0000_0000, 64'h0, 64'h0});
        offer_key({64'h0200_0000_0000_0000, 64'h0, 64'h5});
        offer_key({64'h0200_0000_0000_0000, 64'h0, 64'h5});
        offer_key({64'h0300_0000_0000_0000, 64'h0, 64'h0});

        // A few keys per page, so that the page fills and rolls over.
        settle();
        write_reg(REG_PAGE_BYTES, 32'd200);
        write_reg(REG_HDR_BYTES, 32'd9);
        for (int i = 1; i <= 9; i++)
        begin
            offer_key({64'hA000_0000_0000_0000, 64'h0, 64'(i)});
        end
        cursor = {64'hA000_0000_0000_0000, 64'h0, 64'h9};

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0:       begin pg = 65535; hd = 0;  end
                1:       begin pg = 64;    hd = 0;  end
                2:       begin pg = 65535; hd = 40; end
                3:       begin pg = 48;    hd = 40; end
                4:       begin pg = 200;   hd = 9;  end
                5:       begin pg = 64;    hd = 40; end
                default: begin pg = $urandom_range(64, 1000); hd = $urandom_range(0, 40); end
            endcase
            write_reg(REG_PAGE_BYTES, APB_DATA_W'(pg));
            write_reg(REG_HDR_BYTES, APB_DATA_W'(hd));
            if (ph == 1)
            begin
                press_arm = 1'b1;
            end
            src_max  = (ph == 4) ? 0 : 12;
            sink_max = (ph == 4) ? 0 : 12;
            for (int n = 0; n < PER_PHASE; n++)
            begin
                k = pick_key(cursor, anchor);
                offer_key(k);
                cursor = k;
                if ($urandom_range(0, 15) == 0)
                begin
                    anchor = k;
                end
            end
        end

        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
